[sv/bfk_pkg.sv]
// bfk_pkg: shared types and constants for the bessel evaluator
// no dependencies
package bfk_pkg;
  localparam int ORDER_W = 4;
  localparam int X_W = 20;
  localparam int VALUE_W = 32;
  localparam logic [X_W-1:0] X_MAX = 20'd786431;
  localparam logic signed [63:0] EPS_Q40 = 64'sd10995;
  localparam logic signed [63:0] ONE_Q40 = 64'sd1 <<< 40;
  localparam logic signed [63:0] REC_BOUND = 64'sd1 <<< 56;

  typedef enum logic [3:0] {
    OP_NONE = 4'b0001,
    OP_SERIES = 4'b0010,
    OP_REC = 4'b0100,
    OP_FINAL = 4'b1000
  } op_t;

  typedef struct packed {
    logic load;
    logic ser_start;
    logic ser_odd;
    logic rec_start;
    logic [4:0] rec_m;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } stat_t;
endpackage

[sv/bfk_if.sv]
// bfk_if: valid/ready channel interfaces for the bessel evaluator
// depends on bfk_pkg
interface bfk_in_if;
  import bfk_pkg::*;
  logic valid;
  logic ready;
  logic [ORDER_W-1:0] order;
  logic [X_W-1:0] x;
  modport source(output valid, order, x, input ready);
  modport sink(input valid, order, x, output ready);
endinterface

interface bfk_out_if;
  import bfk_pkg::*;
  logic valid;
  logic ready;
  logic signed [VALUE_W-1:0] value;
  logic saturated;
  modport source(output valid, value, saturated, input ready);
  modport sink(input valid, value, saturated, output ready);
endinterface

[sv/bfk_div.sv]
// bfk_div: restoring unsigned divider, one quotient bit per cycle
// depends on bfk_pkg
module bfk_div (
  input logic clk,
  input logic rst,
  input logic start,
  input logic [63:0] dividend,
  input logic [63:0] divisor,
  output logic done,
  output logic [63:0] quot,
  output logic [63:0] rem
);
  import bfk_pkg::*;
  logic [6:0] cnt;
  logic busy;
  logic [63:0] dvs;
  logic [64:0] trial;
  assign trial = {1'b0, rem[62:0], quot[63]} - {1'b0, dvs};
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 7'd64;
      quot <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
        quot <= {quot[62:0], 1'b1};
      end else begin
        rem <= {rem[62:0], quot[63]};
        quot <= {quot[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

[sv/bfk_datapath.sv]
// bfk_datapath: series and recurrence arithmetic on a shared divider
// depends on bfk_pkg, bfk_div
module bfk_datapath #(
  parameter int SERIES_TERMS = 20
) (
  input logic clk,
  input logic rst,
  input bfk_pkg::cmd_t cmd,
  input logic [19:0] x_in,
  input logic sat_in,
  output bfk_pkg::stat_t stat,
  output logic signed [31:0] value,
  output logic saturated
);
  import bfk_pkg::*;
  typedef enum logic [6:0] {
    D_IDLE = 7'b0000001, D_MUL = 7'b0000010, D_DIV = 7'b0000100,
    D_RDIV1 = 7'b0001000, D_RDIV2 = 7'b0010000, D_RFIN = 7'b0100000,
    D_ADD = 7'b1000000
  } dst_t;
  dst_t st;
  logic [19:0] xr;
  logic [39:0] xsq;
  logic [63:0] q, mag, mulh, rmag, qt, babs, rprod, rval;
  logic [5:0] rmul;
  logic neg, odd, sat, div_start, div_done, done_r, rlim, dovf;
  logic signed [63:0] sum, a, b;
  logic [5:0] k;
  logic [63:0] div_a, div_b, div_q, div_r;
  logic signed [63:0] term, diff, dclip, v, rnd;

  bfk_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quot(div_q), .rem(div_r)
  );

  assign xsq = x_in * x_in;
  assign term = neg ? -$signed(mag) : $signed(mag);
  assign stat = '{busy: (st != D_IDLE), done: done_r};
  assign babs = 64'(b[63] ? -b : b);
  assign rmul = {cmd.rec_m - 5'd1, 1'b0};
  assign rprod = babs * rmul;
  assign rlim = (rmag > 64'(REC_BOUND)) || (qt >= (64'd1 << 40));
  assign rval = rlim ? 64'(REC_BOUND) : rmag;
  assign diff = (b[63] ? -$signed(rval) : $signed(rval)) - a;
  assign dovf = (diff > REC_BOUND) || (diff < -REC_BOUND);
  assign dclip = (diff > REC_BOUND) ? REC_BOUND :
                 (diff < -REC_BOUND) ? -REC_BOUND : diff;
  assign rnd = (v + 64'sd2048) >>> 12;

  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    done_r <= 1'b0;
    if (rst) begin
      st <= D_IDLE;
    end else begin
      case (st)
        D_IDLE: begin
          if (cmd.load) begin
            xr <= x_in;
            sat <= sat_in;
            q <= {26'd0, xsq[39:2]};
            v <= '0;
          end
          if (cmd.ser_start) begin
            odd <= cmd.ser_odd;
            mag <= cmd.ser_odd ? {21'd0, xr, 23'd0} : 64'(ONE_Q40);
            neg <= 1'b0;
            sum <= '0;
            k <= '0;
            st <= D_ADD;
          end
          if (cmd.rec_start) begin
            st <= D_RDIV1;
            div_start <= 1'b1;
            div_a <= rprod;
            div_b <= {44'd0, xr};
          end
          if (cmd.fin) begin
            if (rnd > 64'sd2147483647) begin
              value <= 32'h7fffffff; saturated <= 1'b1;
            end else if (rnd < -64'sd2147483648) begin
              value <= 32'h80000000; saturated <= 1'b1;
            end else begin
              value <= rnd[31:0]; saturated <= sat;
            end
            done_r <= 1'b1;
          end
        end
        D_ADD: begin
          sum <= sum + term;
          k <= k + 6'd1;
          if (!(((term[63] ? -term : term) > EPS_Q40) &&
                (32'(k) + 1 < SERIES_TERMS))) begin
            a <= b;
            b <= sum + term;
            v <= sum + term;
            st <= D_IDLE;
            done_r <= 1'b1;
          end else begin
            st <= D_MUL;
          end
        end
        D_MUL: begin
          mulh <= mag * q[37:32] + mag[63:32] * q[31:0] +
                  (({32'd0, mag[31:0]} * {32'd0, q[31:0]}) >> 32);
          st <= D_DIV;
        end
        D_DIV: begin
          if (!div_start && !div_done && mulh != '1) begin
            div_a <= mulh;
            div_b <= 64'(k) * 64'(k + {5'd0, odd});
            div_start <= 1'b1;
            mulh <= '1;
          end
          if (div_done) begin
            mag <= div_q;
            neg <= !neg;
            st <= D_ADD;
          end
        end
        D_RDIV1: begin
          if (div_done) begin
            qt <= div_q;
            if (div_q >= (64'd1 << 40)) begin
              sat <= 1'b1;
              st <= D_RFIN;
            end else begin
              div_a <= div_r << 16;
              div_start <= 1'b1;
              st <= D_RDIV2;
            end
          end
        end
        D_RDIV2: begin
          if (div_done) begin
            rmag <= (qt << 16) + div_q;
            st <= D_RFIN;
          end
        end
        D_RFIN: begin
          if (rlim || dovf) sat <= 1'b1;
          a <= b;
          b <= dclip;
          v <= dclip;
          st <= D_IDLE;
          done_r <= 1'b1;
        end
        default: st <= D_IDLE;
      endcase
    end
  end
endmodule

[sv/bfk_ctrl.sv]
// bfk_ctrl: sequencer for series, recurrence and output handshake
// depends on bfk_pkg
module bfk_ctrl #(
  parameter int MAX_ORDER = 15
) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_ready,
  input logic [3:0] order,
  input logic [19:0] x,
  input bfk_pkg::stat_t stat,
  output bfk_pkg::cmd_t cmd,
  output logic [19:0] x_out,
  output logic sat_out,
  output logic out_valid,
  input logic out_ready
);
  import bfk_pkg::*;
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_S0 = 6'b000010, S_W0 = 6'b000100,
    S_S1 = 6'b001000, S_W1 = 6'b010000, S_OUT = 6'b100000
  } state_t;
  state_t st;
  logic [3:0] n, n_cl;
  logic [19:0] x_cl;
  logic sat_cl;
  logic [4:0] m;
  assign in_ready = (st == S_IDLE) && !out_valid;
  assign n_cl = (int'(order) > MAX_ORDER) ? 4'(MAX_ORDER) : order;
  assign x_cl = (x > X_MAX) ? X_MAX : x;
  assign sat_cl = (int'(order) > MAX_ORDER) || (x > X_MAX);

  always_ff @(posedge clk) begin
    cmd <= '0;
    if (rst) begin
      st <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (st)
        S_IDLE: if (in_valid && in_ready) begin
          cmd.load <= 1'b1;
          n <= n_cl;
          x_out <= x_cl;
          sat_out <= sat_cl;
          st <= S_S0;
        end
        S_S0: begin
          if (n >= 4'd2 && x_out == '0) begin
            cmd.fin <= 1'b1;
            st <= S_OUT;
          end else begin
            cmd.ser_start <= 1'b1;
            cmd.ser_odd <= (n == 4'd1);
            st <= S_W0;
          end
        end
        S_W0: if (stat.done) begin
          if (n <= 4'd1) begin
            cmd.fin <= 1'b1; st <= S_OUT;
          end else begin
            st <= S_S1;
          end
        end
        S_S1: begin
          cmd.ser_start <= 1'b1; cmd.ser_odd <= 1'b1; st <= S_W1; m <= 5'd2;
        end
        S_W1: if (stat.done) begin
          if (m > {1'b0, n}) begin
            cmd.fin <= 1'b1; st <= S_OUT;
          end else begin
            cmd.rec_start <= 1'b1; cmd.rec_m <= m; m <= m + 5'd1;
            st <= S_W1;
          end
        end
        S_OUT: if (stat.done) begin
          out_valid <= 1'b1; st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

[sv/bessel_first_kind_eval_top.sv]
// bessel_first_kind_eval_top: J_n(x) evaluator, one item at a time
// series terms and recurrence steps are paced by the shared 64-bit radix-2
// divider: one division per series term after the first, up to two per step
// one item in flight, the next is accepted once the result is taken
// synchronous active-high reset clears control state
module bessel_first_kind_eval_top #(
  parameter int MAX_ORDER = 15,
  parameter int SERIES_TERMS = 20
) (
  input logic clk,
  input logic rst,
  bfk_in_if.sink in_ch,
  bfk_out_if.source out_ch
);
  import bfk_pkg::*;
  cmd_t cmd;
  stat_t stat;
  logic [19:0] x_c;
  logic sat_c;
  bfk_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .order(in_ch.order), .x(in_ch.x), .stat(stat), .cmd(cmd),
    .x_out(x_c), .sat_out(sat_c), .out_valid(out_ch.valid), .out_ready(out_ch.ready)
  );
  bfk_datapath #(.SERIES_TERMS(SERIES_TERMS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .x_in(x_c), .sat_in(sat_c),
    .stat(stat), .value(out_ch.value), .saturated(out_ch.saturated)
  );
endmodule

[sv/bfk_checker.sv]
// bfk_checker: port-level assertions for the bessel evaluator
// depends on bessel_first_kind_eval_top
module bfk_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  a_one: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

bind bessel_first_kind_eval_top bfk_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);

[verif/testbench.sv]
// testbench for bessel_first_kind_eval_top: directed and random J_n(x) items,
// each result checked against an in-bench fixed-point evaluator
// depends on bfk_pkg, bfk_if and the top level in sv/
`timescale 1ns / 100ps

module testbench;
  import bfk_pkg::*;

  localparam int N_MAX = 15;
  localparam int TERMS = 20;
  localparam int RANDOM_ITEMS = 1500;
  localparam longint CYCLE_LIMIT = 40_000_000;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic saturated;
  } bessel_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bfk_in_if in_ch();
  bfk_out_if out_ch();

  bessel_first_kind_eval_top #(
    .MAX_ORDER(N_MAX),
    .SERIES_TERMS(TERMS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  bessel_res_t pending_results[$];
  int err_count = 0;
  int checked = 0;
  int sent = 0;
  int sat_seen = 0;
  int burst_left = 0;
  longint cycles = 0;
  int stall_phase = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.order = '0;
    in_ch.x = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic signed [63:0] series_q40(logic [X_W-1:0] xv, bit odd);
    logic [63:0] q;
    logic [63:0] mag;
    logic [127:0] prod;
    logic signed [63:0] term;
    logic signed [63:0] aterm;
    logic signed [63:0] sum;
    bit neg;
    int k;
    q = ({44'd0, xv} * {44'd0, xv}) >> 2;
    mag = odd ? ({44'd0, xv} << 23) : ONE_Q40;
    neg = 0;
    sum = 0;
    k = 0;
    while (1) begin
      term = neg ? -$signed(mag) : $signed(mag);
      sum += term;
      k++;
      aterm = (term < 0) ? -term : term;
      if (!(aterm > EPS_Q40 && k < TERMS)) break;
      prod = {64'd0, mag} * {64'd0, q};
      mag = prod[95:32] / 64'(k * (k + int'(odd)));
      neg = !neg;
    end
    return sum;
  endfunction

  function automatic logic signed [63:0] rec_scale(logic signed [63:0] j, int m,
                                                   logic [X_W-1:0] xv, inout bit sat);
    logic [63:0] mag;
    logic [63:0] qt;
    logic [63:0] rm;
    logic [63:0] res;
    logic [63:0] xw;
    xw = {44'd0, xv};
    mag = 64'((j < 0) ? -j : j) * 64'(2 * (m - 1));
    qt = mag / xw;
    rm = mag % xw;
    if (qt >= (64'd1 << 40)) begin
      sat = 1;
      res = REC_BOUND;
    end else begin
      res = (qt << 16) + ((rm << 16) / xw);
      if (res > 64'(REC_BOUND)) begin
        sat = 1;
        res = REC_BOUND;
      end
    end
    return (j < 0) ? -$signed(res) : $signed(res);
  endfunction

  function automatic bessel_res_t predict_bessel(logic [ORDER_W-1:0] ord, logic [X_W-1:0] xin);
    bessel_res_t r;
    bit sat;
    int n;
    logic [X_W-1:0] xv;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] c;
    logic signed [63:0] v;
    logic signed [63:0] q28;
    sat = 0;
    n = ord;
    xv = xin;
    if (xv > X_MAX) begin
      xv = X_MAX;
      sat = 1;
    end
    if (n > N_MAX) begin
      n = N_MAX;
      sat = 1;
    end
    if (n == 0) begin
      v = series_q40(xv, 0);
    end else if (n == 1) begin
      v = series_q40(xv, 1);
    end else if (xv == 0) begin
      v = 0;
    end else begin
      a = series_q40(xv, 0);
      b = series_q40(xv, 1);
      for (int m = 2; m <= n; m++) begin
        c = rec_scale(b, m, xv, sat) - a;
        if (c > REC_BOUND) begin
          c = REC_BOUND;
          sat = 1;
        end else if (c < -REC_BOUND) begin
          c = -REC_BOUND;
          sat = 1;
        end
        a = b;
        b = c;
      end
      v = b;
    end
    q28 = (v + 64'sd2048) >>> 12;
    if (q28 > 64'sd2147483647) begin
      q28 = 64'sd2147483647;
      sat = 1;
    end else if (q28 < -64'sd2147483648) begin
      q28 = -64'sd2147483648;
      sat = 1;
    end
    r.value = q28[31:0];
    r.saturated = sat;
    return r;
  endfunction

  task automatic send_item(logic [ORDER_W-1:0] ord, logic [X_W-1:0] xv);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    in_ch.valid <= 1'b1;
    in_ch.order <= ord;
    in_ch.x <= xv;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_bessel(ord, xv));
    sent++;
    burst_left--;
  endtask

  // receiver stall pattern: free-running stretches, light and heavy stalls
  always @(posedge clk) begin
    bessel_res_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (cycles % 500 == 0) stall_phase = $urandom_range(0, 2);
      case (stall_phase)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 9) == 0);
      endcase
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result value=%0d saturated=%0b", out_ch.value, out_ch.saturated);
          err_count++;
        end else begin
          e = pending_results.pop_front();
          checked++;
          if (e.saturated) sat_seen++;
          if (out_ch.value !== e.value) begin
            $error("value: expected %0d actual %0d", e.value, out_ch.value);
            err_count++;
          end
          if (out_ch.saturated !== e.saturated) begin
            $error("saturated: expected %0b actual %0b", e.saturated, out_ch.saturated);
            err_count++;
          end
        end
      end
    end
  end

  task automatic test_directed_extremes();
    send_item(0, 0);
    send_item(1, 0);
    send_item(2, 0);
    send_item(15, 0);
    send_item(0, 1);
    send_item(1, 1);
    send_item(2, 1);
    send_item(15, 1);
    send_item(0, X_MAX);
    send_item(1, X_MAX);
    send_item(15, X_MAX);
    send_item(0, X_MAX + 20'd1);
    send_item(5, X_MAX + 20'd1);
    send_item(1, 20'hFFFFF);
    send_item(15, 20'hFFFFF);
    for (int n = 0; n < 4; n++) send_item(4'(n), 20'h10000);
    send_item(8, 20'h00100);
  endtask

  task automatic test_random_items();
    logic [X_W-1:0] xv;
    int pick;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) xv = 20'($urandom_range(X_MAX + 1, 20'hFFFFF));
      else if (pick == 1) xv = 20'($urandom_range(0, 255));
      else xv = 20'($urandom_range(0, X_MAX));
      send_item(4'($urandom_range(0, 15)), xv);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_random_items();
    @(posedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4000) @(posedge clk);
    $display("sent %0d items over orders 0..15 and the full argument range", sent);
    $display("checked %0d results, %0d of them saturated", checked, sat_seen);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
